[hdl/madt_pkg.sv]
// madt_pkg: shared types and constants for the madt table stream parser
// used by madt_front, madt_queue and madt_table_stream_parser_top
package madt_pkg;

    localparam int MAX_PROCESSORS = 64;
    localparam int MAX_IO_APICS   = 8;
    localparam int MAX_OVERRIDES  = 16;

    localparam logic [31:0] HDR_BYTES = 32'd44;
    localparam logic [31:0] MAX_TABLE = 32'd1048576;
    localparam int          NUM_EBYTES = 12;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [7:0] SIG_BYTES [4] = '{8'h41, 8'h50, 8'h49, 8'h43};

    localparam logic [7:0] ET_PROCESSOR = 8'd0;
    localparam logic [7:0] ET_IOAPIC    = 8'd1;
    localparam logic [7:0] ET_OVERRIDE  = 8'd2;
    localparam logic [7:0] ET_LAPIC_ADDR = 8'd5;

    localparam logic [1:0] KIND_PROCESSOR = 2'd0;
    localparam logic [1:0] KIND_IOAPIC    = 2'd1;
    localparam logic [1:0] KIND_OVERRIDE  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TOO_MANY  = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_CAPACITY  = 2'd2;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic        is_final;
        logic [7:0]  id_first;
        logic [7:0]  id_second;
        logic [31:0] word_first;
        logic [15:0] word_second;
        logic [15:0] interrupt_base_high;
        logic [1:0]  status;
        logic [63:0] apic_address;
        logic [31:0] table_flags;
        logic [6:0]  processor_total;
        logic [3:0]  ioapic_total;
    } rec_t;

    typedef struct packed {
        logic [1:0] num;
        rec_t       first;
        rec_t       second;
    } push_t;

endpackage

[hdl/madt_front.sv]
// madt_front: byte parser, header checks, entry decode and record build
// depends on madt_pkg
module madt_front
    import madt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output push_t      wr
);

    logic [20:0] pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] hl_reg, hl_next;
    logic        sig_reg, sig_next;
    logic [31:0] flags_reg, flags_next;
    logic [63:0] laddr_reg, laddr_next;
    logic [20:0] nes_reg, nes_next;
    logic [7:0]  eb_reg [NUM_EBYTES];
    logic [7:0]  eb_cur [NUM_EBYTES];
    logic [15:0] etl_reg, etl_next;
    logic [6:0]  cproc_reg, cproc_next;
    logic [3:0]  cio_reg, cio_next;
    logic [4:0]  cov_reg, cov_next;
    logic [1:0]  fee_reg, fee_next;

    logic        gate;
    logic [20:0] idx;
    logic [7:0]  etype;
    logic [7:0]  elen;
    logic [31:0] w4, w8;
    logic [31:0] total;
    logic        hdr_ok;
    logic        emit;
    rec_t        erec;
    rec_t        srec;

    always_comb
    begin
        for (int i = 0; i < NUM_EBYTES; i++)
        begin
            eb_cur[i] = (gate && idx == 21'(i)) ? data_byte : eb_reg[i];
        end
    end

    assign w4 = {eb_cur[7], eb_cur[6], eb_cur[5], eb_cur[4]};
    assign w8 = {eb_cur[11], eb_cur[10], eb_cur[9], eb_cur[8]};

    assign gate = sig_reg && hl_reg >= HDR_BYTES && hl_reg <= MAX_TABLE &&
                  pos_reg >= HDR_BYTES[20:0] && {11'b0, pos_reg} < hl_reg &&
                  fee_reg == ERR_NONE && pos_reg >= nes_reg;
    assign idx  = pos_reg - nes_reg;

    always_comb
    begin
        sum_next   = sum_reg + data_byte;
        sig_next   = sig_reg;
        hl_next    = hl_reg;
        flags_next = flags_reg;
        laddr_next = laddr_reg;
        nes_next   = nes_reg;
        etl_next   = etl_reg;
        cproc_next = cproc_reg;
        cio_next   = cio_reg;
        cov_next   = cov_reg;
        fee_next   = fee_reg;
        etype      = etl_reg[7:0];
        elen       = etl_reg[15:8];
        emit       = 1'b0;
        erec       = '0;

        if (pos_reg < 21'd4)
        begin
            if (data_byte != SIG_BYTES[pos_reg[1:0]])
            begin
                sig_next = 1'b0;
            end
        end
        else if (pos_reg < 21'd8)
        begin
            hl_next[pos_reg[1:0]*8 +: 8] = hl_reg[pos_reg[1:0]*8 +: 8] | data_byte;
        end
        else if (pos_reg >= 21'd36 && pos_reg < 21'd40)
        begin
            laddr_next[pos_reg[1:0]*8 +: 8] = laddr_reg[pos_reg[1:0]*8 +: 8] | data_byte;
        end
        else if (pos_reg >= 21'd40 && pos_reg < 21'd44)
        begin
            flags_next[pos_reg[1:0]*8 +: 8] = flags_reg[pos_reg[1:0]*8 +: 8] | data_byte;
        end

        if (gate)
        begin
            if (idx == 21'd0)
            begin
                etl_next = {8'd0, data_byte};
                if (hl_reg - {11'b0, pos_reg} < 32'd2)
                begin
                    fee_next = ERR_MALFORMED;
                end
            end
            else
            begin
                if (idx == 21'd1)
                begin
                    elen     = data_byte;
                    etl_next = {data_byte, etype};
                    if (data_byte < 8'd2 ||
                        {24'd0, data_byte} > hl_reg - {11'b0, nes_reg})
                    begin
                        fee_next = ERR_MALFORMED;
                    end
                    else if (etype == ET_PROCESSOR)
                    begin
                        if (data_byte < 8'd8)
                            fee_next = ERR_MALFORMED;
                        else if (cproc_reg >= 7'(MAX_PROCESSORS))
                            fee_next = ERR_CAPACITY;
                    end
                    else if (etype == ET_IOAPIC)
                    begin
                        if (data_byte < 8'd12)
                            fee_next = ERR_MALFORMED;
                        else if (cio_reg >= 4'(MAX_IO_APICS))
                            fee_next = ERR_CAPACITY;
                    end
                    else if (etype == ET_OVERRIDE)
                    begin
                        if (data_byte < 8'd10)
                            fee_next = ERR_MALFORMED;
                        else if (cov_reg >= 5'(MAX_OVERRIDES))
                            fee_next = ERR_CAPACITY;
                    end
                    else if (etype == ET_LAPIC_ADDR)
                    begin
                        if (data_byte < 8'd12)
                            fee_next = ERR_MALFORMED;
                    end
                end
                if (fee_next == ERR_NONE)
                begin
                    if (etype == ET_PROCESSOR && idx == 21'd7)
                    begin
                        if (w4[1:0] != 2'b00)
                        begin
                            emit                 = 1'b1;
                            erec.record_kind     = KIND_PROCESSOR;
                            erec.id_first        = eb_cur[2];
                            erec.id_second       = eb_cur[3];
                            erec.word_first      = w4;
                            cproc_next           = cproc_reg + 7'd1;
                        end
                    end
                    else if (etype == ET_IOAPIC && idx == 21'd11)
                    begin
                        emit                     = 1'b1;
                        erec.record_kind         = KIND_IOAPIC;
                        erec.id_first            = eb_cur[2];
                        erec.word_first          = w4;
                        erec.word_second         = w8[15:0];
                        erec.interrupt_base_high = w8[31:16];
                        cio_next                 = cio_reg + 4'd1;
                    end
                    else if (etype == ET_OVERRIDE && idx == 21'd9)
                    begin
                        emit             = 1'b1;
                        erec.record_kind = KIND_OVERRIDE;
                        erec.id_first    = eb_cur[2];
                        erec.id_second   = eb_cur[3];
                        erec.word_first  = w4;
                        erec.word_second = {eb_cur[9], eb_cur[8]};
                        cov_next         = cov_reg + 5'd1;
                    end
                    else if (etype == ET_LAPIC_ADDR && idx == 21'd11)
                    begin
                        laddr_next = {w8, w4};
                    end
                    if (idx == {13'd0, elen} - 21'd1)
                    begin
                        nes_next = nes_reg + {13'd0, elen};
                    end
                end
            end
        end
    end

    assign pos_next = (pos_reg == {21{1'b1}}) ? pos_reg : pos_reg + 21'd1;
    assign total    = {11'b0, pos_reg} + 32'd1;
    assign hdr_ok   = sig_next && hl_next >= HDR_BYTES && hl_next <= MAX_TABLE &&
                      total == hl_next && sum_next == 8'd0;

    always_comb
    begin
        srec                 = '0;
        srec.record_kind     = KIND_SUMMARY;
        srec.is_final        = 1'b1;
        srec.apic_address    = laddr_next;
        srec.table_flags     = flags_next;
        srec.processor_total = cproc_next;
        srec.ioapic_total    = cio_next;
        if (!hdr_ok)
            srec.status = ST_INVALID;
        else if (fee_next == ERR_MALFORMED)
            srec.status = ST_INVALID;
        else if (fee_next == ERR_CAPACITY)
            srec.status = ST_TOO_MANY;
        else if (laddr_next == 64'd0 || cproc_next == 7'd0 || cio_next == 4'd0)
            srec.status = ST_INVALID;
        else
            srec.status = ST_OK;
    end

    always_comb
    begin
        wr = '0;
        if (in_valid)
        begin
            if (emit)
            begin
                wr.first  = erec;
                wr.second = srec;
                wr.num    = is_last ? 2'd2 : 2'd1;
            end
            else if (is_last)
            begin
                wr.first = srec;
                wr.num   = 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && gate && idx < 21'(NUM_EBYTES))
        begin
            eb_reg[idx[3:0]] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            hl_reg    <= '0;
            sig_reg   <= 1'b1;
            flags_reg <= '0;
            laddr_reg <= '0;
            nes_reg   <= HDR_BYTES[20:0];
            etl_reg   <= '0;
            cproc_reg <= '0;
            cio_reg   <= '0;
            cov_reg   <= '0;
            fee_reg   <= ERR_NONE;
        end
        else if (in_valid)
        begin
            if (is_last)
            begin
                pos_reg   <= '0;
                sum_reg   <= '0;
                hl_reg    <= '0;
                sig_reg   <= 1'b1;
                flags_reg <= '0;
                laddr_reg <= '0;
                nes_reg   <= HDR_BYTES[20:0];
                etl_reg   <= '0;
                cproc_reg <= '0;
                cio_reg   <= '0;
                cov_reg   <= '0;
                fee_reg   <= ERR_NONE;
            end
            else
            begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                hl_reg    <= hl_next;
                sig_reg   <= sig_next;
                flags_reg <= flags_next;
                laddr_reg <= laddr_next;
                nes_reg   <= nes_next;
                etl_reg   <= etl_next;
                cproc_reg <= cproc_next;
                cio_reg   <= cio_next;
                cov_reg   <= cov_next;
                fee_reg   <= fee_next;
            end
        end
    end

endmodule

[hdl/madt_queue.sv]
// madt_queue: short record queue, up to two requests written per cycle
// depends on madt_pkg
module madt_queue
    import madt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t wr,
    output logic  full,
    output logic  empty,
    input  logic  pop,
    output rec_t  head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rec_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg > CW'(QUEUE_DEPTH - 2));
    assign do_pop = pop && !empty;
    assign head   = mem[rp_reg];
    assign cnt_next = cnt_reg + CW'(wr.num) - CW'(do_pop);

    always_ff @(posedge clk)
    begin
        if (wr.num != 2'd0)
        begin
            mem[wp_reg] <= wr.first;
        end
        if (wr.num == 2'd2)
        begin
            mem[wp_reg + PW'(1)] <= wr.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(wr.num);
            rp_reg  <= rp_reg + PW'(do_pop);
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("record queue overflow");
    a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.num != 2'd0) |-> !full)
        else $error("record write while queue full");
    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.is_final == (head.record_kind == KIND_SUMMARY)))
        else $error("summary marker and kind disagree");
`endif

endmodule

[hdl/madt_table_stream_parser_top.sv]
// madt_table_stream_parser_top: madt byte stream parser, front parser plus record queue
// depends on madt_pkg, madt_front, madt_queue
//
// Takes one table byte per cycle with no gaps needed; each byte is parsed in the cycle it
// is accepted and its records (at most an entry record and the closing summary) enter a
// four-deep record queue. full rises when fewer than two slots are free, so input keeps
// flowing at one byte per cycle as long as the result side pops; the first record appears
// in the cycle after the byte that completes it.
module madt_table_stream_parser_top
    import madt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  record_kind,
    output logic        is_final,
    output logic [7:0]  id_first,
    output logic [7:0]  id_second,
    output logic [31:0] word_first,
    output logic [15:0] word_second,
    output logic [15:0] interrupt_base_high,
    output logic [1:0]  status,
    output logic [63:0] apic_address,
    output logic [31:0] table_flags,
    output logic [6:0]  processor_total,
    output logic [3:0]  ioapic_total
);

    push_t wr;
    rec_t  head;

    madt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push && !full),
        .data_byte (data_byte),
        .is_last   (is_last),
        .wr        (wr)
    );

    madt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (full),
        .empty (empty),
        .pop   (pop),
        .head  (head)
    );

    assign record_kind         = head.record_kind;
    assign is_final            = head.is_final;
    assign id_first            = head.id_first;
    assign id_second           = head.id_second;
    assign word_first          = head.word_first;
    assign word_second         = head.word_second;
    assign interrupt_base_high = head.interrupt_base_high;
    assign status              = head.status;
    assign apic_address        = head.apic_address;
    assign table_flags         = head.table_flags;
    assign processor_total     = head.processor_total;
    assign ioapic_total        = head.ioapic_total;

endmodule
